// ===== rtl/core/pic_pkg.sv =====
`default_nettype none

package pic_pkg;

    localparam int IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int MAP_DEPTH = 256;
    localparam int PALETTE_SIZE = 256;
    localparam int CFG_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] PALETTE_CAP = CNT_W'(PALETTE_SIZE);
    localparam logic [IDX_W-1:0] PALETTE_LAST = IDX_W'(PALETTE_SIZE - 1);
    localparam logic [CNT_W-1:0] COLOR_COUNT_RESET = CNT_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSP_PRESENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSP_INDEX   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/pic_if.sv =====
`default_nettype none

interface pic_pix_if;
    logic                     valid;
    logic                     ready;
    logic [pic_pkg::IDX_W-1:0] old_index;
    logic                     frame_last;

    modport source (output valid, output old_index, output frame_last, input ready);
    modport sink   (input valid, input old_index, input frame_last, output ready);
endinterface

interface pic_res_if;
    logic                     valid;
    logic                     ready;
    logic [pic_pkg::IDX_W-1:0] new_index;
    logic                     first_use;
    logic [pic_pkg::IDX_W-1:0] source_index;
    logic                     range_error;
    logic                     last;
    logic [pic_pkg::CNT_W-1:0] used_count;
    logic                     out_transp_present;
    logic [pic_pkg::IDX_W-1:0] out_transp_index;

    modport source (output valid, output new_index, output first_use, output source_index,
                    output range_error, output last, output used_count,
                    output out_transp_present, output out_transp_index, input ready);
    modport sink   (input valid, input new_index, input first_use, input source_index,
                    input range_error, input last, input used_count,
                    input out_transp_present, input out_transp_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/palette_index_compactor_core.sv =====
`default_nettype none

// Palette index compactor.
// pix (sink) takes one pixel per transfer: old_index and frame_last.
// res (source) gives one result per pixel: the dense new index, a first-use
// flag with the echoed source index, a range error flag, and on the last pixel
// of a frame the used colour count and the remapped transparent index.
// wr_en / wr_index / wr_data write the three configuration registers
// (colour count, transparent present, transparent index); the user must
// write them only while idle, as the block itself does not enforce it.
// A new pixel is taken only after the previous one has passed a lookup state
// (index map read and write-back), on the last pixel of a frame a summary
// state (transparent entry read) and an emit state loading the output register.
// The result sits in an output register; a new pixel is taken while it waits,
// and that pixel stalls before its own result until the receiver drains it.
// Reset clears the valid bits of the map, the colour counter and the
// registers (colour count 256, no transparent colour); the map RAM itself is
// not cleared and needs no clearing pass. The last pixel of a frame clears
// the valid bits and the counter at once.
module palette_index_compactor_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pic_pix_if.sink                              pix,
    pic_res_if.source                            res,
    input  wire logic                            wr_en,
    input  wire logic [pic_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [pic_pkg::CFG_W-1:0]       wr_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_SUMM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [pic_pkg::CNT_W-1:0]     color_count_reg;
    logic                          transp_present_reg;
    logic [pic_pkg::IDX_W-1:0]     transp_index_reg;

    logic [pic_pkg::MAP_DEPTH-1:0] map_valid_reg;
    logic [pic_pkg::CNT_W-1:0]     next_new_reg;

    logic [pic_pkg::IDX_W-1:0]     c_reg;
    logic                          last_reg;

    logic [pic_pkg::IDX_W-1:0]     k_reg;
    logic                          first_reg;
    logic                          rerr_reg;
    logic                          fwd_reg;
    logic [pic_pkg::CNT_W-1:0]     used_reg;
    logic                          tp_reg;
    logic [pic_pkg::IDX_W-1:0]     ti_reg;

    logic                          out_valid_reg;
    logic [pic_pkg::IDX_W-1:0]     out_new_reg;
    logic                          out_first_reg;
    logic [pic_pkg::IDX_W-1:0]     out_src_reg;
    logic                          out_rerr_reg;
    logic                          out_last_reg;
    logic [pic_pkg::CNT_W-1:0]     out_used_reg;
    logic                          out_tp_reg;
    logic [pic_pkg::IDX_W-1:0]     out_ti_reg;

    logic                          pix_xfer;
    logic                          out_free;
    logic                          hit;
    logic                          room;
    logic                          alloc;
    logic [pic_pkg::IDX_W-1:0]     k_val;
    logic                          tp_val;

    logic                          ram_we;
    logic [pic_pkg::IDX_W-1:0]     ram_raddr;
    logic [pic_pkg::IDX_W-1:0]     ram_rdata;

    assign pix.ready = (state_reg == ST_IDLE);
    assign pix_xfer  = pix.valid && pix.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign hit   = map_valid_reg[c_reg];
    assign room  = next_new_reg < pic_pkg::PALETTE_CAP;
    assign alloc = !hit && room;

    always_comb
    begin
        priority if (hit)
        begin
            k_val = ram_rdata;
        end
        else if (room)
        begin
            k_val = next_new_reg[pic_pkg::IDX_W-1:0];
        end
        else
        begin
            k_val = pic_pkg::PALETTE_LAST;
        end
    end

    assign tp_val = transp_present_reg && map_valid_reg[transp_index_reg];

    // Read the pixel entry on transfer, the transparent entry during write-back.
    assign ram_raddr = (state_reg == ST_IDLE) ? pix.old_index : transp_index_reg;
    assign ram_we    = (state_reg == ST_LOOK) && alloc;

    pic_ram #(
        .WIDTH (pic_pkg::IDX_W),
        .DEPTH (pic_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (next_new_reg[pic_pkg::IDX_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_xfer)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = last_reg ? ST_SUMM : ST_EMIT;
            end
            ST_SUMM:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            color_count_reg    <= pic_pkg::COLOR_COUNT_RESET;
            transp_present_reg <= 1'b0;
            transp_index_reg   <= '0;
            map_valid_reg      <= '0;
            next_new_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                unique case (wr_index)
                    pic_pkg::REG_COLOR_COUNT:    color_count_reg    <= wr_data;
                    pic_pkg::REG_TRANSP_PRESENT: transp_present_reg <= wr_data[0];
                    pic_pkg::REG_TRANSP_INDEX:
                        transp_index_reg <= wr_data[pic_pkg::IDX_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (ram_we)
            begin
                map_valid_reg[c_reg] <= 1'b1;
                next_new_reg         <= next_new_reg + 1'b1;
            end

            // Drop the frame map once the summary has been taken.
            if (state_reg == ST_SUMM)
            begin
                map_valid_reg <= '0;
                next_new_reg  <= '0;
            end

            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            c_reg    <= pix.old_index;
            last_reg <= pix.frame_last;
        end

        if (state_reg == ST_LOOK)
        begin
            k_reg     <= k_val;
            first_reg <= alloc;
            rerr_reg  <= {1'b0, c_reg} >= color_count_reg;
            // The transparent entry may be the one written in this very cycle.
            fwd_reg   <= alloc && (transp_index_reg == c_reg);
            used_reg  <= '0;
            tp_reg    <= 1'b0;
            ti_reg    <= '0;
        end

        if (state_reg == ST_SUMM)
        begin
            used_reg <= next_new_reg;
            tp_reg   <= tp_val;
            if (!tp_val)
            begin
                ti_reg <= '0;
            end
            else if (fwd_reg)
            begin
                ti_reg <= k_reg;
            end
            else
            begin
                ti_reg <= ram_rdata;
            end
        end

        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_new_reg   <= k_reg;
            out_first_reg <= first_reg;
            out_src_reg   <= c_reg;
            out_rerr_reg  <= rerr_reg;
            out_last_reg  <= last_reg;
            out_used_reg  <= used_reg;
            out_tp_reg    <= tp_reg;
            out_ti_reg    <= ti_reg;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.new_index          = out_new_reg;
    assign res.first_use          = out_first_reg;
    assign res.source_index       = out_src_reg;
    assign res.range_error        = out_rerr_reg;
    assign res.last               = out_last_reg;
    assign res.used_count         = out_used_reg;
    assign res.out_transp_present = out_tp_reg;
    assign res.out_transp_index   = out_ti_reg;

`ifndef SYNTHESIS
    a_look_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> $past(pix_xfer))
        else $error("lookup without a pixel transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_new_reg <= pic_pkg::PALETTE_CAP)
        else $error("colour counter beyond palette size");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(map_valid_reg) == 32'(next_new_reg))
        else $error("valid bits and colour counter disagree");

    a_emit_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && !out_free |=> (state_reg == ST_EMIT) && out_valid_reg)
        else $error("result lost while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pic_ram.sv =====
`default_nettype none

module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/pic_checker.sv =====
`default_nettype none

module pic_checker
    import pic_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    pic_pix_if                        pix,
    pic_res_if                        res,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data,
    output int                        fail_count,
    output int                        outstanding,
    output int                        frames_seen,
    output int                        first_uses,
    output int                        range_errors
);

    typedef struct packed {
        logic [IDX_W-1:0] new_index;
        logic             first_use;
        logic [IDX_W-1:0] source_index;
        logic             range_error;
        logic             last;
        logic [CNT_W-1:0] used_count;
        logic             out_transp_present;
        logic [IDX_W-1:0] out_transp_index;
    } pic_result_t;

    // shadow registers
    logic [CNT_W-1:0] cfg_colour_count;
    logic             cfg_transp_present;
    logic [IDX_W-1:0] cfg_transp_index;

    // per-frame renumbering state
    logic [IDX_W-1:0]     colour_map [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] seen;
    logic [CNT_W-1:0]     next_colour;

    pic_result_t pending_results [$];
    int          n_bad = 0;
    int          n_reported = 0;
    int          n_frames = 0;
    int          n_first = 0;
    int          n_range = 0;

    assign fail_count   = n_bad;
    assign frames_seen  = n_frames;
    assign first_uses   = n_first;
    assign range_errors = n_range;

    function automatic pic_result_t renumber_pixel(input logic [IDX_W-1:0] old_idx,
                                                   input logic             frame_end);
        pic_result_t r;
        r = '0;
        if (seen[old_idx])
        begin
            r.new_index = colour_map[old_idx];
        end
        else if (next_colour < PALETTE_CAP)
        begin
            r.new_index         = next_colour[IDX_W-1:0];
            r.first_use         = 1'b1;
            colour_map[old_idx] = next_colour[IDX_W-1:0];
            seen[old_idx]       = 1'b1;
            next_colour         = next_colour + 1'b1;
        end
        else
        begin
            // palette exhausted: pin to the top entry, allocate nothing
            r.new_index = PALETTE_LAST;
        end
        r.source_index = old_idx;
        r.range_error  = ({1'b0, old_idx} >= cfg_colour_count);
        r.last         = frame_end;
        if (frame_end)
        begin
            // summary is taken after this pixel has been mapped
            r.used_count = next_colour;
            if (cfg_transp_present && seen[cfg_transp_index])
            begin
                r.out_transp_present = 1'b1;
                r.out_transp_index   = colour_map[cfg_transp_index];
            end
            seen        = '0;
            next_colour = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            n_bad++;
            if (n_reported < 10)
            begin
                n_reported++;
                $display("mismatch on %s: expected %0h, got %0h", fname, want_v, got_v);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pic_result_t want;
        if (!rst_n)
        begin
            cfg_colour_count   = COLOR_COUNT_RESET;
            cfg_transp_present = 1'b0;
            cfg_transp_index   = '0;
            seen               = '0;
            next_colour        = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    n_bad++;
                    if (n_reported < 10)
                    begin
                        n_reported++;
                        $display("result transfer with nothing expected: new_index %0h",
                                 res.new_index);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("new_index", 32'(want.new_index), 32'(res.new_index));
                    check_field("first_use", 32'(want.first_use), 32'(res.first_use));
                    check_field("source_index", 32'(want.source_index),
                                32'(res.source_index));
                    check_field("range_error", 32'(want.range_error),
                                32'(res.range_error));
                    check_field("last", 32'(want.last), 32'(res.last));
                    check_field("used_count", 32'(want.used_count), 32'(res.used_count));
                    check_field("out_transp_present", 32'(want.out_transp_present),
                                32'(res.out_transp_present));
                    check_field("out_transp_index", 32'(want.out_transp_index),
                                32'(res.out_transp_index));
                end
            end
            // pixel first, so a write in the same cycle applies from the next pixel
            if (pix.valid && pix.ready)
            begin
                want = renumber_pixel(pix.old_index, pix.frame_last);
                pending_results.push_back(want);
                if (want.last)
                    n_frames++;
                if (want.first_use)
                    n_first++;
                if (want.range_error)
                    n_range++;
            end
            if (wr_en)
            begin
                case (wr_index)
                    REG_COLOR_COUNT:    cfg_colour_count   = wr_data[CNT_W-1:0];
                    REG_TRANSP_PRESENT: cfg_transp_present = wr_data[0];
                    REG_TRANSP_INDEX:   cfg_transp_index   = wr_data[IDX_W-1:0];
                    default:            ;
                endcase
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import pic_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_TARGET = 1120;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    pic_pix_if pix_ch ();
    pic_res_if res_ch ();

    int fail_count;
    int outstanding;
    int frames_seen;
    int first_uses;
    int range_errors;

    int  cycle_count = 0;
    int  sent = 0;
    int  phases = 0;
    int  rx_hold = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    palette_index_compactor_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix_ch),
        .res      (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    pic_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix_ch),
        .res          (res_ch),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .frames_seen  (frames_seen),
        .first_uses   (first_uses),
        .range_errors (range_errors)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("** palette_index_compactor_core: FAILED **");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            res_ch.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 30)
        begin
            res_ch.ready <= 1'b0;
            rx_hold      <= pick_gap();
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // hold valid until the transfer; keep it high when the next pixel follows at once
    task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic frame_end);
        int gap;
        pix_ch.valid      <= 1'b1;
        pix_ch.old_index  <= idx;
        pix_ch.frame_last <= frame_end;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        sent++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    // write all registers back to back, then the spare index, which must be ignored
    task automatic set_config(input logic [CFG_W-1:0] colours, input logic tp,
                              input logic [IDX_W-1:0] ti);
        wait_idle();
        phases++;
        wr_en    <= 1'b1;
        wr_index <= REG_COLOR_COUNT;
        wr_data  <= colours;
        @(posedge clk);
        wr_index <= REG_TRANSP_PRESENT;
        wr_data  <= {{(CFG_W-1){1'b0}}, tp};
        @(posedge clk);
        wr_index <= REG_TRANSP_INDEX;
        wr_data  <= {1'b0, ti};
        @(posedge clk);
        wr_index <= REG_SPARE;
        wr_data  <= CFG_W'($urandom);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] colours;
        logic             tp;
        logic [IDX_W-1:0] ti;
        logic [IDX_W-1:0] base;
        int               span;
        int               len;
        int               nframes;
        logic [IDX_W-1:0] perm [MAP_DEPTH];
        int               j;
        logic [IDX_W-1:0] tmp;

        pix_ch.valid      <= 1'b0;
        pix_ch.old_index  <= '0;
        pix_ch.frame_last <= 1'b0;
        wr_en             <= 1'b0;
        wr_index          <= '0;
        wr_data           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register values straight out of reset
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b1);

        // one-entry palette; transparent colour first seen on the last pixel
        set_config(9'd1, 1'b1, 8'd9);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd9, 1'b1);

        // zero colour count: everything out of range; transparent colour absent, then alone
        set_config(9'd0, 1'b1, 8'd0);
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd5, 1'b1);
        send_pixel(8'd0, 1'b1);

        // count beyond the palette: nothing out of range
        set_config(9'd511, 1'b0, 8'd255);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b1);

        set_config(9'd256, 1'b1, 8'd255);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);

        // every colour once: the count reaches the full palette
        set_config(9'd256, 1'b1, 8'($urandom));
        for (int i = 0; i < MAP_DEPTH; i++)
            perm[i] = IDX_W'(i);
        for (int i = MAP_DEPTH - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < MAP_DEPTH; i++)
            send_pixel(perm[i], i == MAP_DEPTH - 1);

        while (sent < RANDOM_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       colours = 9'd0;
                1:       colours = 9'd1;
                2:       colours = 9'd256;
                3:       colours = CFG_W'($urandom_range(257, 511));
                default: colours = CFG_W'($urandom_range(1, 256));
            endcase
            base = IDX_W'($urandom);
            span = ($urandom_range(0, 5) == 0) ? 256 : $urandom_range(1, 12);
            tp   = 1'($urandom);
            if ($urandom_range(0, 2) != 0)
                ti = base + IDX_W'($urandom_range(0, span - 1));
            else
                ti = IDX_W'($urandom);
            set_config(colours, tp, ti);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(1, 5);
            for (int f = 0; f < nframes; f++)
            begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20)
                                                    : $urandom_range(30, 120);
                for (int p = 0; p < len; p++)
                    send_pixel(base + IDX_W'($urandom_range(0, span - 1)), p == len - 1);
            end
        end

        wait_idle();
        $display("%0d pixels in %0d frames over %0d register settings", sent, frames_seen,
                 phases);
        $display("%0d first uses, %0d out-of-range pixels", first_uses, range_errors);
        if (fail_count == 0)
            $display("** palette_index_compactor_core: PASSED **");
        else
            $display("** palette_index_compactor_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
